// ===== hw/rtl/cq_pkg.sv =====
// ----------------------------------------------------------------------------
// cq_pkg
// Shared types and constants for the circular queue core.
// ----------------------------------------------------------------------------
package cq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // per-cycle control broadcast to every cell in the chain
  typedef struct packed {
    logic shift;   // dequeue: every cell takes its right neighbor
    logic rotate;  // list: occupied cells rotate one place toward the head
    logic load;    // enqueue: first empty cell captures the new word
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/cq_if.sv =====
// ----------------------------------------------------------------------------
// cq_if
// Valid/ready channels for the circular queue: command in, results out.
// ----------------------------------------------------------------------------
interface cq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  command;
  logic signed [31:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface cq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] data_out;
  logic               last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

// ===== hw/rtl/cq_cell.sv =====
// ----------------------------------------------------------------------------
// cq_cell
// One queue slot: a word plus an occupied bit, linked to its neighbors.
// ----------------------------------------------------------------------------
module cq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cq_pkg::cell_ctrl_t        ctrl,
  input  logic                      left_valid,
  input  logic                      right_valid,
  input  logic [cq_pkg::DATA_W-1:0] right_data,
  input  logic [cq_pkg::DATA_W-1:0] head_data,
  input  logic [cq_pkg::DATA_W-1:0] enq_data,
  output logic                      valid_o,
  output logic [cq_pkg::DATA_W-1:0] data_o
);
  import cq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.shift) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctrl.rotate) begin
      // newest occupied cell wraps around to take the head word
      if (valid_r) begin
        data_nxt = right_valid ? right_data : head_data;
      end
    end else if (ctrl.load && !valid_r && left_valid) begin
      valid_nxt = 1'b1;
      data_nxt  = enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== hw/rtl/circular_queue_core.sv =====
// ----------------------------------------------------------------------------
// circular_queue_core
// Fixed-depth FIFO of signed words built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Enqueue, dequeue, peek and refused commands: one beat in, one result beat
// out in the next cycle; one command per cycle when the result side keeps up.
// List: count result beats from the head cell, one per cycle unless stalled,
// while occupied cells rotate once around; no new command until the last beat.
// Synchronous active-low reset empties the queue; stored words are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_core #(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  cq_in_if.sink    in_ch,
  cq_out_if.source out_ch
);
  import cq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  // cell chain: cell 0 holds the oldest word whenever no list walk is running
  cell_ctrl_t        ctrl;
  logic [DEPTH-1:0]  cell_valid;
  logic [DATA_W-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv;
    logic              rv;
    logic [DATA_W-1:0] rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_link
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    cq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_valid  (lv),
      .right_valid (rv),
      .right_data  (rd),
      .head_data   (cell_data[0]),
      .enq_data    (DATA_W'(in_ch.data_in)),
      .valid_o     (cell_valid[i]),
      .data_o      (cell_data[i])
    );
  end

  // control and output register
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;   // occupancy
  logic [CNT_W-1:0]  idx_r, idx_nxt;       // beats already sent in a list
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              last_r, last_nxt;

  logic slot_free;
  logic in_fire;
  logic list_fire;
  logic full;
  logic empty;
  logic list_last;
  cmd_t cmd;

  assign cmd       = cmd_t'(in_ch.command);
  assign full      = cell_valid[DEPTH-1];
  assign empty     = !cell_valid[0];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign list_fire = (state_r == S_LIST) && slot_free;
  assign list_last = (idx_r == count_r - CNT_W'(1));

  always_comb begin
    ctrl        = '0;
    ctrl.shift  = in_fire && (cmd == CMD_DEQ) && !empty;
    ctrl.load   = in_fire && (cmd == CMD_ENQ) && !full;
    ctrl.rotate = list_fire;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    data_nxt      = data_r;
    last_nxt      = last_r;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      data_nxt      = '0;
      last_nxt      = 1'b1;
      unique case (cmd)
        CMD_ENQ: begin
          if (full) begin
            status_nxt = ST_OVER;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DEQ: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            data_nxt  = cell_data[0];
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_PEEK: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            data_nxt = cell_data[0];
          end
        end
        CMD_LIST: begin
          if (empty) begin
            status_nxt = ST_UNDER;
          end else begin
            // results come from the list walk; nothing this cycle
            out_valid_nxt = 1'b0;
            idx_nxt       = '0;
            state_nxt     = S_LIST;
          end
        end
        default: begin
          status_nxt = ST_UNDER;
        end
      endcase
    end else if (list_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      data_nxt      = cell_data[0];
      last_nxt      = list_last;
      idx_nxt       = idx_r + CNT_W'(1);
      if (list_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      data_r      <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      data_r      <= data_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.data_out = $signed(data_r);
  assign out_ch.last     = last_r;

endmodule

// ===== test/circular_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// circular_queue_core_tb
// Self-checking bench for the circular queue core. Command beats come from a
// backlog that the stimulus thread fills phase by phase. An in-bench queue
// model predicts every result beat. Result beats are checked field by field
// in order. Sender gaps, receiver stalls and one long receiver hold-off
// exercise the handshakes.
// ----------------------------------------------------------------------------
module circular_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cq_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int          IDX_W       = $clog2(DEPTH);
  localparam int          IDLE_LIMIT  = 2000;       // cycles with no beat while work is open
  localparam int          HOLD_CYCLES = 80;         // long receiver hold-off
  localparam int          TAIL_CYCLES = DEPTH + 4;  // settle time after the last result

  typedef struct {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  word;
  } queue_cmd_t;

  typedef struct {
    status_t                   status;
    logic signed [DATA_W-1:0]  word;
    logic                      last;
  } queue_result_t;

  logic clk;
  logic rst_n;

  cq_in_if  in_ch ();
  cq_out_if out_ch ();

  circular_queue_core #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // command beats not yet accepted; the driver always offers the front one
  queue_cmd_t    cmd_backlog[$];
  // result beats predicted but not yet seen, oldest first
  queue_result_t pending_results[$];

  // queue model: word store, head/tail slots and occupancy
  logic signed [DATA_W-1:0] model_words [DEPTH];
  logic [IDX_W-1:0]         model_head;
  logic [IDX_W-1:0]         model_tail;
  int                       model_fill;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  long_hold_go;
  bit  hold_taken;
  int  hold_count;
  bit  in_taken;
  int  idle_run;
  int  err_count;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] slot);
    return (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // Applies one command to the model and queues the result beats it causes.
  function automatic void predict_queue_op(cmd_t op, logic signed [DATA_W-1:0] word);
    logic [IDX_W-1:0] slot;
    int               k;
    if (op == CMD_ENQ) begin
      if (model_fill == DEPTH) begin
        // full: refused, nothing moves
        pending_results.push_back(queue_result_t'{ST_OVER, '0, 1'b1});
      end else begin
        model_words[model_tail] = word;
        model_tail = next_slot(model_tail);
        model_fill++;
        pending_results.push_back(queue_result_t'{ST_OK, '0, 1'b1});
      end
    end else if (model_fill == 0) begin
      // dequeue, peek and list all refuse an empty queue
      pending_results.push_back(queue_result_t'{ST_UNDER, '0, 1'b1});
    end else begin
      slot = model_head;
      case (op)
        CMD_DEQ: begin
          pending_results.push_back(queue_result_t'{ST_OK, model_words[slot], 1'b1});
          model_head = next_slot(model_head);
          model_fill--;
        end
        CMD_PEEK: begin
          pending_results.push_back(queue_result_t'{ST_OK, model_words[slot], 1'b1});
        end
        default: begin
          // list walks oldest to newest; only the newest carries last
          for (k = 0; k < model_fill; k++) begin
            pending_results.push_back(
              queue_result_t'{ST_OK, model_words[slot], (k == model_fill - 1)});
            slot = next_slot(slot);
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input cmd_t op, input logic signed [DATA_W-1:0] word);
    cmd_backlog.push_back(queue_cmd_t'{op, word});
  endtask

  // Random traffic in runs that lean toward filling or toward draining, so the
  // queue keeps swinging between empty, wrapped and full.
  task automatic queue_burst(input int n);
    int                       i;
    int                       roll;
    int                       run_left;
    bit                       filling;
    cmd_t                     op;
    logic signed [DATA_W-1:0] word;
    run_left = 0;
    filling  = 1'b1;
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        filling  = 1'($urandom_range(0, 1));
        run_left = $urandom_range(3, 10);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 65)      op = CMD_ENQ;
        else if (roll < 78) op = CMD_DEQ;
        else if (roll < 90) op = CMD_PEEK;
        else                op = CMD_LIST;
      end else begin
        if (roll < 15)      op = CMD_ENQ;
        else if (roll < 70) op = CMD_DEQ;
        else if (roll < 85) op = CMD_PEEK;
        else                op = CMD_LIST;
      end
      case ($urandom_range(0, 9))
        0:       word = 32'sh7FFF_FFFF;
        1:       word = 32'sh8000_0000;
        default: word = $urandom();
      endcase
      push_cmd(op, word);
    end
  endtask

  // Sender pause: hold back new beats until every expected result is in.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: offers the backlog front at the falling edge and holds it
  // until the beat is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd_backlog[0].command;
        in_ch.data_in <= cmd_backlog[0].word;
      end else begin
        in_ch.valid   <= 1'b0;
        in_ch.data_in <= $urandom();  // junk payload while idle
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off on request. The
  // hold-off is counted here so it runs independently of the sender.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_go && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_count   <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count   <= hold_count - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge, checks result beats
  // against the model, feeds accepted commands to the model, and runs the
  // watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    queue_cmd_t    beat;
    queue_result_t want;
    bit            in_fire;
    bit            out_fire;
    in_fire  = rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
    out_fire = rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1;
    in_taken = in_fire;

    // result side first; a command taken this edge cannot answer this edge
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat: status %0d data %h last %0b",
                 $time, out_ch.status, out_ch.data_out, out_ch.last);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          err_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_ch.status);
        end
        if (out_ch.data_out !== want.word) begin
          err_count++;
          $display("%0t: data_out mismatch: expected %h, actual %h",
                   $time, want.word, out_ch.data_out);
        end
        if (out_ch.last !== want.last) begin
          err_count++;
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_ch.last);
        end
      end
    end

    if (in_fire) begin
      beat = cmd_backlog.pop_front();
      predict_queue_op(beat.command, beat.word);
    end

    // watchdog: only counts while something is still owed
    if ((cmd_backlog.size() != 0 || pending_results.size() != 0) && !in_fire && !out_fire) begin
      idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_run);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      idle_run = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_ENQ;
    in_ch.data_in  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_go   = 1'b0;
    err_count      = 0;
    idle_run       = 0;
    model_head     = '0;
    model_tail     = '0;
    model_fill     = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // -- directed: empty refusals, fill to full, overflow, wrap, drain --------
    push_cmd(CMD_PEEK, 32'sh1234_5678);      // all three refused on empty
    push_cmd(CMD_DEQ,  -32'sd1);
    push_cmd(CMD_LIST, '0);
    push_cmd(CMD_ENQ,  32'sh7FFF_FFFF);      // word extremes and bit patterns
    push_cmd(CMD_ENQ,  32'sh8000_0000);
    push_cmd(CMD_ENQ,  -32'sd1);
    push_cmd(CMD_ENQ,  '0);
    push_cmd(CMD_ENQ,  32'sh5555_5555);
    push_cmd(CMD_ENQ,  32'shAAAA_AAAA);
    push_cmd(CMD_ENQ,  32'sd1);
    push_cmd(CMD_ENQ,  $urandom());          // queue now full
    push_cmd(CMD_ENQ,  32'sh0BAD_F00D);      // refused: overflow
    push_cmd(CMD_LIST, $urandom());          // full listing, eight beats
    push_cmd(CMD_PEEK, $urandom());
    for (i = 0; i < 3; i++) push_cmd(CMD_DEQ, $urandom());
    push_cmd(CMD_ENQ,  $urandom());          // tail wraps to slot zero
    push_cmd(CMD_LIST, $urandom());          // listing across the wrap
    for (i = 0; i < 6; i++) push_cmd(CMD_DEQ, $urandom());
    push_cmd(CMD_PEEK, $urandom());          // emptied by dequeue, slots not zero
    push_cmd(CMD_ENQ,  32'sh1357_9BDF);
    push_cmd(CMD_LIST, $urandom());          // single entry: first beat is last
    wait_drained();

    // -- random phases with different idling ---------------------------------
    queue_burst(15);                         // full rate
    wait_drained();

    send_idle_pct = 73;                      // sparse sender
    queue_burst(15);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 73;                     // slow receiver
    queue_burst(15);
    wait_drained();

    send_idle_pct  = 24;                     // both sides idle now and then
    recv_stall_pct = 24;
    queue_burst(15);
    wait_drained();

    // -- back pressure: receiver holds off while the sender keeps offering ---
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_go   = 1'b1;
    queue_burst(15);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
